// ===== design/hta_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hta_pkg: shared types and constants of the handle table allocator
// Command and status codes, control states and default table sizes.
// ----------------------------------------------------------------------------
package hta_pkg;

    localparam int SLOTS_DEF          = 32;
    localparam int RESERVED_SLOTS_DEF = 3;

    localparam int CMD_W    = 3;
    localparam int SLOT_W   = 5;
    localparam int VALUE_W  = 32;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_OPEN  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_SET   = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CLOSE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_TEST  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_READ  = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_REFUSED = 2'd2;

    typedef enum logic {
        S_IDLE,
        S_READ
    } t_state;

endpackage

// ===== design/hta_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hta_ram: simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module hta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== design/handle_table_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// handle_table_allocator_core: bitmap slot allocator with value store
// Open grabs the lowest free slot, close frees it, set/test/read access slots.
// ----------------------------------------------------------------------------
//  channel   valid     ready     payload
//  command   i_valid   o_ready   i_cmd, i_slot, i_value
//  result    o_valid   i_ready   o_status, o_granted_slot, o_read_value,
//                                o_occupied
//
//  open, set_entry, close, test and unknown commands load the result register
//  directly; read_entry first waits in S_READ for the registered read port of the store.
//  the single result register empties in the cycle its word is taken, so a
//  new word can be accepted in that same cycle.
//  reset marks the reserved slots busy and clears per-slot valid bits, so
//  a never-written slot reads as zero; no clearing pass is needed.
//  a waiting result blocks new words, and read_entry blocks them while in
//  the S_READ state.
// ----------------------------------------------------------------------------
module handle_table_allocator_core #(
    parameter int SLOTS          = hta_pkg::SLOTS_DEF,
    parameter int RESERVED_SLOTS = hta_pkg::RESERVED_SLOTS_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [hta_pkg::CMD_W-1:0]           i_cmd,
    input  logic [hta_pkg::SLOT_W-1:0]          i_slot,
    input  logic signed [hta_pkg::VALUE_W-1:0]  i_value,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic [hta_pkg::STATUS_W-1:0]        o_status,
    output logic [hta_pkg::SLOT_W-1:0]          o_granted_slot,
    output logic signed [hta_pkg::VALUE_W-1:0]  o_read_value,
    output logic                                o_occupied
);

    localparam int AW = $clog2(SLOTS);

    hta_pkg::t_state r_state, n_state;

    logic [SLOTS-1:0] r_busy, n_busy;
    logic [SLOTS-1:0] r_vld, n_vld;
    logic             r_rd_ok, n_rd_ok;

    logic                                r_out_valid, n_out_valid;
    logic [hta_pkg::STATUS_W-1:0]        r_status, n_status;
    logic [hta_pkg::SLOT_W-1:0]          r_granted, n_granted;
    logic signed [hta_pkg::VALUE_W-1:0]  r_read_value, n_read_value;
    logic                                r_occupied, n_occupied;

    logic                        in_fire;
    logic                        in_range;
    logic [AW-1:0]               slot_a;
    logic                        busy_at;
    logic                        close_ok;
    logic                        free_found;
    logic [AW-1:0]               free_idx;
    logic                        ram_we;
    logic [AW-1:0]               ram_waddr;
    logic [hta_pkg::VALUE_W-1:0] ram_rdata;

    assign o_ready  = (r_state == hta_pkg::S_IDLE) && (!r_out_valid || i_ready);
    assign in_fire  = i_valid && o_ready;
    assign in_range = 32'(i_slot) < SLOTS;
    assign slot_a   = AW'(i_slot);
    assign busy_at  = in_range ? r_busy[slot_a] : 1'b0;
    assign close_ok = busy_at && (32'(i_slot) >= RESERVED_SLOTS);

    // lowest free slot
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = 0; i < SLOTS; i++) begin
            if (!free_found && !r_busy[i]) begin
                free_found = 1'b1;
                free_idx   = AW'(i);
            end
        end
    end

    hta_ram #(
        .WIDTH (hta_pkg::VALUE_W),
        .DEPTH (SLOTS)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (i_value),
        .i_raddr (slot_a),
        .o_rdata (ram_rdata)
    );

    always_comb begin
        n_state      = r_state;
        n_busy       = r_busy;
        n_vld        = r_vld;
        n_rd_ok      = r_rd_ok;
        n_out_valid  = r_out_valid;
        n_status     = r_status;
        n_granted    = r_granted;
        n_read_value = r_read_value;
        n_occupied   = r_occupied;
        ram_we       = 1'b0;
        ram_waddr    = slot_a;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            hta_pkg::S_IDLE: begin
                if (in_fire) begin
                    n_out_valid  = 1'b1;
                    n_status     = hta_pkg::ST_OK;
                    n_granted    = '0;
                    n_read_value = '0;
                    n_occupied   = 1'b0;
                    case (i_cmd)
                        hta_pkg::CMD_OPEN: begin
                            if (free_found) begin
                                n_busy[free_idx] = 1'b1;
                                n_vld[free_idx]  = 1'b1;
                                ram_we           = 1'b1;
                                ram_waddr        = free_idx;
                                n_granted        = hta_pkg::SLOT_W'(free_idx);
                            end else begin
                                n_status = hta_pkg::ST_FULL;
                            end
                        end
                        hta_pkg::CMD_SET: begin
                            if (in_range) begin
                                ram_we        = 1'b1;
                                n_vld[slot_a] = 1'b1;
                            end
                        end
                        hta_pkg::CMD_CLOSE: begin
                            if (close_ok) begin
                                n_busy[slot_a] = 1'b0;
                            end else begin
                                n_status = hta_pkg::ST_REFUSED;
                            end
                        end
                        hta_pkg::CMD_TEST: begin
                            n_occupied = busy_at;
                        end
                        hta_pkg::CMD_READ: begin
                            // result waits for the store's read data
                            n_out_valid = 1'b0;
                            n_rd_ok     = in_range ? r_vld[slot_a] : 1'b0;
                            n_state     = hta_pkg::S_READ;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            hta_pkg::S_READ: begin
                n_out_valid  = 1'b1;
                n_read_value = r_rd_ok ? ram_rdata : '0;
                n_state      = hta_pkg::S_IDLE;
            end
            default: begin
                n_state = hta_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= hta_pkg::S_IDLE;
            r_out_valid <= 1'b0;
            r_rd_ok     <= 1'b0;
            r_vld       <= '0;
            for (int i = 0; i < SLOTS; i++) begin
                r_busy[i] <= (i < RESERVED_SLOTS);
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_ok     <= n_rd_ok;
            r_vld       <= n_vld;
            r_busy      <= n_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_granted    <= n_granted;
        r_read_value <= n_read_value;
        r_occupied   <= n_occupied;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_granted_slot = r_granted;
    assign o_read_value   = r_read_value;
    assign o_occupied     = r_occupied;

    // reserved slots never become free
    logic [SLOTS-1:0] res_mask;
    always_comb begin
        for (int i = 0; i < SLOTS; i++) begin
            res_mask[i] = (i < RESERVED_SLOTS);
        end
    end

    a_reserved_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_busy & res_mask) == res_mask)
        else $error("reserved slot freed");

    a_read_out_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == hta_pkg::S_READ) |-> !r_out_valid)
        else $error("result register busy while read is pending");

    a_open_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_fire && (i_cmd == hta_pkg::CMD_OPEN) && free_found)
        |=> (r_busy[$past(free_idx)] && r_vld[$past(free_idx)]))
        else $error("granted slot not marked busy");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the handle table allocator
// Directed commands cover the reserved slots, refused closes, writes to free
// slots, extreme values and undefined command codes. Random fill, drain and
// mixed bursts then run the table to full and back many times. A clocked
// predictor tracks busy bits and stored values, and every result word is
// compared field by field, in order. Both channels idle in random bursts.
// ----------------------------------------------------------------------------
module tb_top;

    localparam int N_SLOTS     = hta_pkg::SLOTS_DEF;
    localparam int N_RSV       = hta_pkg::RESERVED_SLOTS_DEF;
    localparam int RAND_ITEMS  = 950;
    localparam int QUIET_ITEMS = 60;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = 8;

    localparam logic [hta_pkg::CMD_W-1:0] CMD_UNDEF_A = 3'd5;
    localparam logic [hta_pkg::CMD_W-1:0] CMD_UNDEF_B = 3'd6;
    localparam logic [hta_pkg::CMD_W-1:0] CMD_UNDEF_C = 3'd7;

    localparam logic [hta_pkg::VALUE_W-1:0] VAL_MAX  = 32'h7fff_ffff;
    localparam logic [hta_pkg::VALUE_W-1:0] VAL_MIN  = 32'h8000_0000;
    localparam logic [hta_pkg::VALUE_W-1:0] VAL_ONES = 32'hffff_ffff;

    typedef struct packed {
        logic [hta_pkg::CMD_W-1:0]   cmd;
        logic [hta_pkg::SLOT_W-1:0]  slot;
        logic [hta_pkg::VALUE_W-1:0] value;
    } t_cmd_word;

    typedef struct packed {
        logic [hta_pkg::STATUS_W-1:0] status;
        logic [hta_pkg::SLOT_W-1:0]   granted;
        logic [hta_pkg::VALUE_W-1:0]  rd_value;
        logic                         occ;
    } t_slot_result;

    logic                                i_clk;
    logic                                i_rst_n;
    logic                                i_valid;
    logic                                o_ready;
    logic [hta_pkg::CMD_W-1:0]           i_cmd;
    logic [hta_pkg::SLOT_W-1:0]          i_slot;
    logic signed [hta_pkg::VALUE_W-1:0]  i_value;
    logic                                o_valid;
    logic                                i_ready;
    logic [hta_pkg::STATUS_W-1:0]        o_status;
    logic [hta_pkg::SLOT_W-1:0]          o_granted_slot;
    logic signed [hta_pkg::VALUE_W-1:0]  o_read_value;
    logic                                o_occupied;

    handle_table_allocator_core #(
        .SLOTS          (N_SLOTS),
        .RESERVED_SLOTS (N_RSV)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_cmd          (i_cmd),
        .i_slot         (i_slot),
        .i_value        (i_value),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_status       (o_status),
        .o_granted_slot (o_granted_slot),
        .o_read_value   (o_read_value),
        .o_occupied     (o_occupied)
    );

    always begin
        i_clk = 1'b0;
        #1;
        i_clk = 1'b1;
        #1;
    end

    // predicted table contents
    logic [N_SLOTS-1:0]          busy_bits;
    logic [hta_pkg::VALUE_W-1:0] slot_vals [N_SLOTS];

    t_cmd_word    pending_cmds [$];
    t_slot_result expected_results [$];
    t_cmd_word    next_word;

    int  total_items;
    int  n_accepted;
    int  n_checked;
    int  err_count;
    int  idle_run;
    int  send_gap;
    int  hold_gap;
    int  calm_left;
    bit  cmd_taken;
    bit  tail_phase;
    int  n_grants;
    int  n_full;
    int  n_refused;
    int  n_reads;

    function automatic t_slot_result apply_command(t_cmd_word w);
        t_slot_result r;
        bit           in_range;
        bit           found;
        r        = '0;
        in_range = (int'(w.slot) < N_SLOTS);
        found    = 1'b0;
        case (w.cmd)
            hta_pkg::CMD_OPEN: begin
                r.status = hta_pkg::ST_FULL;
                for (int i = 0; i < N_SLOTS; i++) begin
                    if (!found && !busy_bits[i]) begin
                        found        = 1'b1;
                        busy_bits[i] = 1'b1;
                        slot_vals[i] = w.value;
                        r.status     = hta_pkg::ST_OK;
                        r.granted    = i[hta_pkg::SLOT_W-1:0];
                    end
                end
                if (found) n_grants++;
                else n_full++;
            end
            hta_pkg::CMD_SET: begin
                if (in_range) slot_vals[w.slot] = w.value;
            end
            hta_pkg::CMD_CLOSE: begin
                if (in_range && busy_bits[w.slot] && int'(w.slot) >= N_RSV) begin
                    busy_bits[w.slot] = 1'b0;
                end else begin
                    r.status = hta_pkg::ST_REFUSED;
                    n_refused++;
                end
            end
            hta_pkg::CMD_TEST: begin
                r.occ = in_range && busy_bits[w.slot];
            end
            hta_pkg::CMD_READ: begin
                if (in_range) r.rd_value = slot_vals[w.slot];
                n_reads++;
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic t_cmd_word make_word(logic [hta_pkg::CMD_W-1:0] cmd, int slot,
                                            logic [hta_pkg::VALUE_W-1:0] value);
        t_cmd_word w;
        w.cmd   = cmd;
        w.slot  = slot[hta_pkg::SLOT_W-1:0];
        w.value = value;
        return w;
    endfunction

    function automatic logic [hta_pkg::VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 11))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return VAL_ONES;
            3:       return '0;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [hta_pkg::CMD_W-1:0] pick_cmd();
        int p;
        p = $urandom_range(0, 99);
        if (p < 25) return hta_pkg::CMD_OPEN;
        if (p < 40) return hta_pkg::CMD_SET;
        if (p < 60) return hta_pkg::CMD_CLOSE;
        if (p < 75) return hta_pkg::CMD_TEST;
        if (p < 95) return hta_pkg::CMD_READ;
        case ($urandom_range(0, 2))
            0:       return CMD_UNDEF_A;
            1:       return CMD_UNDEF_B;
            default: return CMD_UNDEF_C;
        endcase
    endfunction

    // long stretches with no idling on either side
    always @(negedge i_clk) begin
        if (calm_left > 0) calm_left <= calm_left - 1;
        else if ($urandom_range(0, 99) == 0) calm_left <= $urandom_range(20, 60);
    end

    // command driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (!i_valid || cmd_taken) begin
            if (send_gap > 0) begin
                send_gap <= send_gap - 1;
                i_valid  <= 1'b0;
            end else if (pending_cmds.size() > 0 && !tail_phase && calm_left == 0 &&
                         $urandom_range(0, 5) == 0) begin
                send_gap <= $urandom_range(0, 2);
                i_valid  <= 1'b0;
            end else if (pending_cmds.size() > 0) begin
                next_word = pending_cmds.pop_front();
                i_valid  <= 1'b1;
                i_cmd    <= next_word.cmd;
                i_slot   <= next_word.slot;
                i_value  <= next_word.value;
            end else begin
                i_valid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else if (hold_gap > 0) begin
            hold_gap <= hold_gap - 1;
            i_ready  <= 1'b0;
        end else if (!tail_phase && calm_left == 0 && $urandom_range(0, 4) == 0) begin
            hold_gap <= $urandom_range(0, 2);
            i_ready  <= 1'b0;
        end else begin
            i_ready <= 1'b1;
        end
    end

    // predictor, checker and watchdog
    always @(posedge i_clk) begin
        t_slot_result want;
        if (!i_rst_n) begin
            cmd_taken <= 1'b0;
            idle_run  <= 0;
        end else begin
            cmd_taken  <= i_valid && o_ready;
            tail_phase <= (pending_cmds.size() < QUIET_ITEMS);
            if (i_valid && o_ready) begin
                expected_results.push_back(apply_command(make_word(i_cmd, i_slot, i_value)));
                n_accepted <= n_accepted + 1;
            end
            if (o_valid && i_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result word with nothing expected: status %0d", o_status);
                    err_count++;
                end else begin
                    want = expected_results.pop_front();
                    n_checked <= n_checked + 1;
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, o_status);
                        err_count++;
                    end
                    if (o_granted_slot !== want.granted) begin
                        $error("granted_slot mismatch: expected %0d, got %0d",
                               want.granted, o_granted_slot);
                        err_count++;
                    end
                    if (o_read_value !== want.rd_value) begin
                        $error("read_value mismatch: expected %0d, got %0d",
                               $signed(want.rd_value), o_read_value);
                        err_count++;
                    end
                    if (o_occupied !== want.occ) begin
                        $error("occupied mismatch: expected %0d, got %0d",
                               want.occ, o_occupied);
                        err_count++;
                    end
                end
            end
            if ((i_valid && o_ready) || (o_valid && i_ready)) idle_run <= 0;
            else idle_run <= idle_run + 1;
            if (idle_run >= STALL_LIMIT) begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial begin
        int added;
        int n;
        int kind;
        i_rst_n    = 1'b0;
        i_valid    = 1'b0;
        i_ready    = 1'b0;
        i_cmd      = hta_pkg::CMD_OPEN;
        i_slot     = '0;
        i_value    = '0;
        cmd_taken  = 1'b0;
        tail_phase = 1'b0;
        send_gap   = 0;
        hold_gap   = 0;
        calm_left  = 0;
        n_accepted = 0;
        n_checked  = 0;
        err_count  = 0;
        idle_run   = 0;
        n_grants   = 0;
        n_full     = 0;
        n_refused  = 0;
        n_reads    = 0;
        for (int i = 0; i < N_SLOTS; i++) begin
            busy_bits[i] = (i < N_RSV);
            slot_vals[i] = '0;
        end

        // reserved slots, refused closes, free-slot writes, extremes
        pending_cmds.push_back(make_word(hta_pkg::CMD_TEST, 0, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_TEST, N_RSV, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_READ, N_SLOTS - 1, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, 0, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, N_RSV - 1, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, 7, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_SET, 9, VAL_MAX));
        pending_cmds.push_back(make_word(hta_pkg::CMD_READ, 9, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_TEST, 9, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_OPEN, 0, VAL_MIN));
        pending_cmds.push_back(make_word(hta_pkg::CMD_OPEN, 31, VAL_ONES));
        pending_cmds.push_back(make_word(hta_pkg::CMD_READ, N_RSV, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, N_RSV, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_OPEN, 0, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_SET, 0, 32'h5555_5555));
        pending_cmds.push_back(make_word(hta_pkg::CMD_READ, 0, '0));
        pending_cmds.push_back(make_word(CMD_UNDEF_A, 31, VAL_ONES));
        pending_cmds.push_back(make_word(CMD_UNDEF_B, 0, '0));
        pending_cmds.push_back(make_word(CMD_UNDEF_C, 31, VAL_ONES));
        pending_cmds.push_back(make_word(hta_pkg::CMD_SET, N_SLOTS - 1, 32'haaaa_aaaa));
        pending_cmds.push_back(make_word(hta_pkg::CMD_READ, N_SLOTS - 1, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, N_RSV + 1, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE, N_RSV + 1, '0));
        pending_cmds.push_back(make_word(hta_pkg::CMD_TEST, N_SLOTS - 1, VAL_ONES));

        // random bursts: fill to full, drain, mixed traffic, read-back sweeps
        added = 0;
        while (added < RAND_ITEMS) begin
            kind = $urandom_range(0, 9);
            if (kind <= 2) begin
                n = $urandom_range(20, 34);
                for (int k = 0; k < n; k++) begin
                    if ($urandom_range(0, 5) == 0)
                        pending_cmds.push_back(make_word(hta_pkg::CMD_READ,
                                               $urandom_range(0, 31), pick_value()));
                    else
                        pending_cmds.push_back(make_word(hta_pkg::CMD_OPEN,
                                               $urandom_range(0, 31), pick_value()));
                end
            end else if (kind <= 4) begin
                n = $urandom_range(10, 30);
                for (int k = 0; k < n; k++)
                    pending_cmds.push_back(make_word(hta_pkg::CMD_CLOSE,
                                           $urandom_range(0, 31), pick_value()));
            end else if (kind <= 8) begin
                n = $urandom_range(5, 20);
                for (int k = 0; k < n; k++)
                    pending_cmds.push_back(make_word(pick_cmd(),
                                           $urandom_range(0, 31), pick_value()));
            end else begin
                n = $urandom_range(4, 12);
                kind = $urandom_range(0, 31);
                for (int k = 0; k < n; k++)
                    pending_cmds.push_back(make_word(
                                           k[0] ? hta_pkg::CMD_TEST : hta_pkg::CMD_READ,
                                           (kind + k) % 32, pick_value()));
            end
            added += n;
        end
        total_items = pending_cmds.size();

        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (n_accepted != total_items || n_checked != n_accepted);
        repeat (DRAIN_WAIT) @(negedge i_clk);

        $display("%0d commands checked: %0d opens granted, %0d on a full table,",
                 n_checked, n_grants, n_full);
        $display("%0d closes refused, %0d reads, with idling on both channels",
                 n_refused, n_reads);
        if (err_count == 0 && expected_results.size() == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/hta_pkg.sv
design/hta_ram.sv
design/handle_table_allocator_core.sv
tb/tb_top.sv
